// File: hdl/fk_pkg.sv
// Shared constants, types and tables for the five-joint forward kinematics block.
// Used by every module under hdl/. Depends on nothing.
package fk_pkg;

    localparam int FRAC_BITS_DEF    = 20;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam longint Q30_HALF_PI  = 64'sd1686629713;
    localparam longint Q30_PI       = 64'sd3373259426;
    localparam longint Q30_TWO_PI   = 64'sd6746518852;
    localparam longint Q30_INV_GAIN = 64'sd652032874;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_UPPER_ARM = 3'd0;
    localparam t_cfg_idx CFG_FOREARM   = 3'd1;
    localparam t_cfg_idx CFG_SHLDR_Y   = 3'd2;
    localparam t_cfg_idx CFG_SHLDR_Z   = 3'd3;
    localparam t_cfg_idx CFG_HAND_X    = 3'd4;
    localparam t_cfg_idx CFG_HAND_Y    = 3'd5;

    localparam logic [18:0]        RST_UPPER_ARM = 19'd94372;
    localparam logic [18:0]        RST_FOREARM   = 19'd53005;
    localparam logic signed [19:0] RST_SHLDR_Y   = 20'sd102760;
    localparam logic signed [19:0] RST_SHLDR_Z   = 20'sd104858;
    localparam logic signed [19:0] RST_HAND_X    = 20'sd16672;
    localparam logic signed [19:0] RST_HAND_Y    = 20'sd60817;

    // arctan(2^-k) in Q.30
    function automatic longint atan_q30(input int k);
        longint v;
        case (k)
            0:       v = 843314857;
            1:       v = 497837829;
            2:       v = 263043837;
            3:       v = 133525159;
            4:       v = 67021687;
            5:       v = 33543516;
            6:       v = 16775851;
            7:       v = 8388437;
            8:       v = 4194283;
            9:       v = 2097149;
            default: v = longint'(1) <<< (30 - k);
        endcase
        return v;
    endfunction

endpackage

// File: hdl/fk_cordic.sv
// One sine/cosine lane: quadrant fold, pipelined rotation-mode CORDIC, rounding, clamping.
// Depends on fk_pkg.
module fk_cordic import fk_pkg::*; #(
    parameter int FRAC      = FRAC_BITS_DEF,
    parameter int STEPS     = CORDIC_STEPS_DEF,
    parameter bit HALF_OFS  = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [15:0]     i_angle,
    output logic signed [FRAC+1:0] o_cos,
    output logic signed [FRAC+1:0] o_sin
);
    localparam int W_R = FRAC + 2;
    localparam int SH  = 30 - FRAC;
    localparam logic signed [33:0] RND = (34'sd1 <<< SH) >>> 1;
    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC;

    logic signed [34:0] z_raw, z_wrap, z_fold;
    logic               flip;
    logic signed [32:0] r_x [STEPS+1];
    logic signed [32:0] r_y [STEPS+1];
    logic signed [32:0] r_z [STEPS+1];
    logic               r_flip [STEPS+1];
    logic signed [33:0] xf, yf, xr, yr;

    always_comb begin
        z_raw = {{2{i_angle[15]}}, i_angle, 17'b0}
              + (HALF_OFS ? 35'(Q30_HALF_PI) : 35'sd0);
        if (z_raw > 35'(Q30_PI)) begin
            z_wrap = z_raw - 35'(Q30_TWO_PI);
        end else if (z_raw < -35'(Q30_PI)) begin
            z_wrap = z_raw + 35'(Q30_TWO_PI);
        end else begin
            z_wrap = z_raw;
        end
        flip = 1'b1;
        if (z_wrap > 35'(Q30_HALF_PI)) begin
            z_fold = z_wrap - 35'(Q30_PI);
        end else if (z_wrap < -35'(Q30_HALF_PI)) begin
            z_fold = z_wrap + 35'(Q30_PI);
        end else begin
            z_fold = z_wrap;
            flip   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= 33'(Q30_INV_GAIN);
            r_y[0]    <= 33'sd0;
            r_z[0]    <= z_fold[32:0];
            r_flip[0] <= flip;
        end
    end

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_flip[k+1] <= r_flip[k];
                    if (r_z[k] >= 0) begin
                        r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                        r_z[k+1] <= r_z[k] - 33'(atan_q30(k));
                    end else begin
                        r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                        r_z[k+1] <= r_z[k] + 33'(atan_q30(k));
                    end
                end
            end
        end
    endgenerate

    // undo the quadrant fold, round down to FRAC bits, clamp to unit range
    always_comb begin
        xf = r_flip[STEPS] ? -34'(r_x[STEPS]) : 34'(r_x[STEPS]);
        yf = r_flip[STEPS] ? -34'(r_y[STEPS]) : 34'(r_y[STEPS]);
        xr = (xf + RND) >>> SH;
        yr = (yf + RND) >>> SH;
        if (xr > ONE)  xr = ONE;
        if (xr < -ONE) xr = -ONE;
        if (yr > ONE)  yr = ONE;
        if (yr < -ONE) yr = -ONE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= $signed(xr[W_R-1:0]);
            o_sin <= $signed(yr[W_R-1:0]);
        end
    end

endmodule

// File: hdl/fk_joint.sv
// One joint of the merge chain: frame times RotZ*TransZ(d)*RotX(+/-pi/2).
// Two stages: rounded products, then sums with clamping. Depends on fk_pkg.
module fk_joint import fk_pkg::*; #(
    parameter int FRAC   = FRAC_BITS_DEF,
    parameter bit SA_NEG = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [FRAC+1:0] i_r [9],
    input  logic signed [FRAC+3:0] i_p [3],
    input  logic signed [FRAC+1:0] i_cos,
    input  logic signed [FRAC+1:0] i_sin,
    input  logic signed [FRAC+3:0] i_d,
    output logic signed [FRAC+1:0] o_r [9],
    output logic signed [FRAC+3:0] o_p [3]
);
    localparam int W_R = FRAC + 2;
    localparam int W_P = FRAC + 4;
    localparam int W_M = W_R + W_P + 1;
    localparam int W_A = FRAC + 6;
    localparam logic signed [W_M-1:0] RND = (W_M'(1) <<< FRAC) >>> 1;
    localparam logic signed [W_A-1:0] ONE = W_A'(1) <<< FRAC;
    localparam logic signed [W_A-1:0] PMAX = W_A'(4) <<< FRAC;

    logic signed [W_R-1:0] s_col, c_col;
    logic signed [W_M-1:0] m_pc [3], m_ps [3], m_qs [3], m_qc [3], m_pd [3];
    logic signed [W_P-1:0] r_pc [3], r_ps [3], r_qs [3], r_qc [3], r_pd [3], r_p [3];
    logic signed [W_R-1:0] r_mid [3];
    logic signed [W_A-1:0] a0 [3], a2 [3], ap [3];

    always_comb begin
        s_col = SA_NEG ? -i_sin : i_sin;
        c_col = SA_NEG ? i_cos : -i_cos;
        for (int i = 0; i < 3; i++) begin
            m_pc[i] = ((i_r[3*i] * i_cos) + RND) >>> FRAC;
            m_ps[i] = ((i_r[3*i+1] * i_sin) + RND) >>> FRAC;
            m_qs[i] = ((i_r[3*i] * s_col) + RND) >>> FRAC;
            m_qc[i] = ((i_r[3*i+1] * c_col) + RND) >>> FRAC;
            m_pd[i] = ((i_r[3*i+2] * i_d) + RND) >>> FRAC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pc[i]  <= m_pc[i][W_P-1:0];
                r_ps[i]  <= m_ps[i][W_P-1:0];
                r_qs[i]  <= m_qs[i][W_P-1:0];
                r_qc[i]  <= m_qc[i][W_P-1:0];
                r_pd[i]  <= m_pd[i][W_P-1:0];
                r_mid[i] <= SA_NEG ? -i_r[3*i+2] : i_r[3*i+2];
                r_p[i]   <= i_p[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a0[i] = W_A'(r_pc[i]) + W_A'(r_ps[i]);
            a2[i] = W_A'(r_qs[i]) + W_A'(r_qc[i]);
            ap[i] = W_A'(r_p[i]) + W_A'(r_pd[i]);
            if (a0[i] > ONE)   a0[i] = ONE;
            if (a0[i] < -ONE)  a0[i] = -ONE;
            if (a2[i] > ONE)   a2[i] = ONE;
            if (a2[i] < -ONE)  a2[i] = -ONE;
            if (ap[i] > PMAX)  ap[i] = PMAX;
            if (ap[i] < -PMAX) ap[i] = -PMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                o_r[3*i]   <= a0[i][W_R-1:0];
                o_r[3*i+1] <= r_mid[i];
                o_r[3*i+2] <= a2[i][W_R-1:0];
                o_p[i]     <= ap[i][W_P-1:0];
            end
        end
    end

endmodule

// File: hdl/fk_hand.sv
// Final merge stage: frame times the fixed hand offset transform.
// Two stages: rounded products, then sums with clamping. Depends on fk_pkg.
module fk_hand import fk_pkg::*; #(
    parameter int FRAC = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [FRAC+1:0] i_r [9],
    input  logic signed [FRAC+3:0] i_p [3],
    input  logic signed [FRAC+3:0] i_hx,
    input  logic signed [FRAC+3:0] i_hy,
    output logic signed [FRAC+1:0] o_r [9],
    output logic signed [FRAC+3:0] o_p [3]
);
    localparam int W_R = FRAC + 2;
    localparam int W_P = FRAC + 4;
    localparam int W_M = W_R + W_P + 1;
    localparam int W_A = FRAC + 6;
    localparam logic signed [W_M-1:0] RND = (W_M'(1) <<< FRAC) >>> 1;
    localparam logic signed [W_A-1:0] PMAX = W_A'(4) <<< FRAC;

    logic signed [W_M-1:0] m_x [3], m_y [3];
    logic signed [W_P-1:0] r_px [3], r_py [3], r_p [3];
    logic signed [W_R-1:0] r_t [9];
    logic signed [W_A-1:0] ap [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_x[i] = ((i_r[3*i] * i_hx) + RND) >>> FRAC;
            m_y[i] = ((i_r[3*i+1] * i_hy) + RND) >>> FRAC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_px[i] <= m_x[i][W_P-1:0];
                r_py[i] <= m_y[i][W_P-1:0];
                r_p[i]  <= i_p[i];
            end
            for (int i = 0; i < 9; i++) begin
                r_t[i] <= i_r[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ap[i] = W_A'(r_p[i]) + W_A'(r_px[i]) + W_A'(r_py[i]);
            if (ap[i] > PMAX)  ap[i] = PMAX;
            if (ap[i] < -PMAX) ap[i] = -PMAX;
        end
    end

    // columns swap and the third column flips sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                o_r[3*i]   <= r_t[3*i+1];
                o_r[3*i+1] <= r_t[3*i];
                o_r[3*i+2] <= -r_t[3*i+2];
                o_p[i]     <= ap[i][W_P-1:0];
            end
        end
    end

endmodule

// File: hdl/dh_arm_forward_kinematics.sv
// Five-joint arm forward kinematics: hand pose in the torso frame.
// Throughput: one item per cycle; five CORDIC lanes run in parallel and feed a
// pipelined chain of joint stages, each of which holds two register stages.
// The whole pipeline advances together; it holds only when the output register is
// full and not taken. Reset (synchronous, active low) clears valids and loads
// the register defaults; no clearing pass.
module dh_arm_forward_kinematics import fk_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_shoulder_pitch_angle,
    input  logic signed [15:0] i_shoulder_roll_angle,
    input  logic signed [15:0] i_elbow_yaw_angle,
    input  logic signed [15:0] i_elbow_roll_angle,
    input  logic signed [15:0] i_wrist_yaw_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_rot_00,
    output logic signed [23:0] o_rot_01,
    output logic signed [23:0] o_rot_02,
    output logic signed [23:0] o_rot_10,
    output logic signed [23:0] o_rot_11,
    output logic signed [23:0] o_rot_12,
    output logic signed [23:0] o_rot_20,
    output logic signed [23:0] o_rot_21,
    output logic signed [23:0] o_rot_22,
    output logic signed [23:0] o_pos_x,
    output logic signed [23:0] o_pos_y,
    output logic signed [23:0] o_pos_z,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_index,
    input  logic [19:0]        i_cfg_data
);
    localparam int W_R = FRAC_BITS + 2;
    localparam int W_P = FRAC_BITS + 4;
    localparam int LAT = CORDIC_STEPS + 15;

    // Q.20 register value to FRAC bits: shift up, or round down
    localparam int SHL_C = (FRAC_BITS >= 20) ? FRAC_BITS - 20 : 0;
    localparam int SHR_C = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;
    localparam int W_C   = FRAC_BITS + 24;
    localparam logic signed [W_C-1:0] RND_C = (W_C'(1) <<< SHR_C) >>> 1;

    // FRAC bits to Q.20 output
    localparam int SHL_O = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;
    localparam int SHR_O = (FRAC_BITS >= 20) ? FRAC_BITS - 20 : 0;
    localparam int W_O   = FRAC_BITS + 12;
    localparam logic signed [W_O-1:0] RND_O = (W_O'(1) <<< SHR_O) >>> 1;
    localparam logic signed [W_O-1:0] OMAX  = W_O'(24'sh7FFFFF);
    localparam logic signed [W_O-1:0] OMIN  = -W_O'(25'sh0800000);
    localparam logic signed [W_R-1:0] ONE_R = W_R'(1) <<< FRAC_BITS;

    localparam bit SA_NEG [5] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    function automatic logic signed [W_P-1:0] to_frac(input logic signed [20:0] v);
        logic signed [W_C-1:0] w;
        w = ((W_C'(v) <<< SHL_C) + RND_C) >>> SHR_C;
        return $signed(w[W_P-1:0]);
    endfunction

    logic [18:0]        r_upper_arm, r_forearm;
    logic signed [19:0] r_shldr_y, r_shldr_z, r_hand_x, r_hand_y;
    logic               en;
    logic [LAT-1:0]     r_vld;
    logic signed [15:0] angle [5];
    logic signed [W_R-1:0] lane_c [5], lane_s [5], joint_c [5], joint_s [5];
    logic signed [W_P-1:0] d [5];
    logic signed [W_R-1:0] f_r [6][9];
    logic signed [W_P-1:0] f_p [6][3];
    logic signed [W_R-1:0] h_r [9];
    logic signed [W_P-1:0] h_p [3];
    logic signed [W_P-1:0] hx, hy;
    logic signed [W_P-1:0] fin [12];
    logic signed [W_O-1:0] conv [12];
    logic signed [23:0]    r_out [12];

    // configuration writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_arm <= RST_UPPER_ARM;
            r_forearm   <= RST_FOREARM;
            r_shldr_y   <= RST_SHLDR_Y;
            r_shldr_z   <= RST_SHLDR_Z;
            r_hand_x    <= RST_HAND_X;
            r_hand_y    <= RST_HAND_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UPPER_ARM: r_upper_arm <= i_cfg_data[18:0];
                CFG_FOREARM:   r_forearm   <= i_cfg_data[18:0];
                CFG_SHLDR_Y:   r_shldr_y   <= $signed(i_cfg_data);
                CFG_SHLDR_Z:   r_shldr_z   <= $signed(i_cfg_data);
                CFG_HAND_X:    r_hand_x    <= $signed(i_cfg_data);
                CFG_HAND_Y:    r_hand_y    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless a finished result waits untaken
    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    assign angle[0] = i_shoulder_pitch_angle;
    assign angle[1] = i_shoulder_roll_angle;
    assign angle[2] = i_elbow_yaw_angle;
    assign angle[3] = i_elbow_roll_angle;
    assign angle[4] = i_wrist_yaw_angle;

    assign d[0] = '0;
    assign d[1] = '0;
    assign d[2] = to_frac($signed({2'b00, r_upper_arm}));
    assign d[3] = '0;
    assign d[4] = to_frac($signed({2'b00, r_forearm}));
    assign hx   = to_frac(21'(r_hand_x));
    assign hy   = to_frac(21'(r_hand_y));

    // torso base frame feeds the first joint
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            f_r[0][i] = '0;
        end
        f_r[0][0] = ONE_R;
        f_r[0][5] = ONE_R;
        f_r[0][7] = -ONE_R;
        f_p[0][0] = '0;
        f_p[0][1] = to_frac(21'(r_shldr_y));
        f_p[0][2] = to_frac(21'(r_shldr_z));
    end

    genvar j, k;
    generate
        for (j = 0; j < 5; j++) begin : g_lane
            fk_cordic #(
                .FRAC     (FRAC_BITS),
                .STEPS    (CORDIC_STEPS),
                .HALF_OFS (j == 1)
            ) u_cordic (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_angle (angle[j]),
                .o_cos   (lane_c[j]),
                .o_sin   (lane_s[j])
            );

            // hold each lane's result until its joint stage comes up
            if (j == 0) begin : g_nodly
                assign joint_c[j] = lane_c[j];
                assign joint_s[j] = lane_s[j];
            end else begin : g_dly
                logic signed [W_R-1:0] r_dc [2*j];
                logic signed [W_R-1:0] r_ds [2*j];
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dc[0] <= lane_c[j];
                        r_ds[0] <= lane_s[j];
                    end
                end
                for (k = 1; k < 2*j; k++) begin : g_tap
                    always_ff @(posedge i_clk) begin
                        if (en) begin
                            r_dc[k] <= r_dc[k-1];
                            r_ds[k] <= r_ds[k-1];
                        end
                    end
                end
                assign joint_c[j] = r_dc[2*j-1];
                assign joint_s[j] = r_ds[2*j-1];
            end

            fk_joint #(
                .FRAC   (FRAC_BITS),
                .SA_NEG (SA_NEG[j])
            ) u_joint (
                .i_clk (i_clk),
                .i_en  (en),
                .i_r   (f_r[j]),
                .i_p   (f_p[j]),
                .i_cos (joint_c[j]),
                .i_sin (joint_s[j]),
                .i_d   (d[j]),
                .o_r   (f_r[j+1]),
                .o_p   (f_p[j+1])
            );
        end
    endgenerate

    fk_hand #(
        .FRAC (FRAC_BITS)
    ) u_hand (
        .i_clk (i_clk),
        .i_en  (en),
        .i_r   (f_r[5]),
        .i_p   (f_p[5]),
        .i_hx  (hx),
        .i_hy  (hy),
        .o_r   (h_r),
        .o_p   (h_p)
    );

    // rescale to Q3.20 and saturate to 24 bits
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            fin[i] = W_P'(h_r[i]);
        end
        for (int i = 0; i < 3; i++) begin
            fin[9+i] = h_p[i];
        end
        for (int i = 0; i < 12; i++) begin
            conv[i] = ((W_O'(fin[i]) <<< SHL_O) + RND_O) >>> SHR_O;
            if (conv[i] > OMAX) conv[i] = OMAX;
            if (conv[i] < OMIN) conv[i] = OMIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 12; i++) begin
                r_out[i] <= conv[i][23:0];
            end
        end
    end

    assign o_rot_00 = r_out[0];
    assign o_rot_01 = r_out[1];
    assign o_rot_02 = r_out[2];
    assign o_rot_10 = r_out[3];
    assign o_rot_11 = r_out[4];
    assign o_rot_12 = r_out[5];
    assign o_rot_20 = r_out[6];
    assign o_rot_21 = r_out[7];
    assign o_rot_22 = r_out[8];
    assign o_pos_x  = r_out[9];
    assign o_pos_y  = r_out[10];
    assign o_pos_z  = r_out[11];

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_rot_unit_00: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rot_00 <= 24'sd1048576 && o_rot_00 >= -24'sd1048576))
        else $error("rotation entry out of unit range");

    a_rot_unit_22: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rot_22 <= 24'sd1048576 && o_rot_22 >= -24'sd1048576))
        else $error("rotation entry out of unit range");
`endif

endmodule
